>>> hdl/stop_distance_velocity_limiter_top_defines.svh
// Assertion macros shared by the checker.
`ifndef STOP_DISTANCE_VELOCITY_LIMITER_TOP_DEFINES_SVH
`define STOP_DISTANCE_VELOCITY_LIMITER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SDVL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SDVL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/sdvl_pkg.sv
`timescale 1ns / 1ps

package sdvl_pkg;

  localparam int ELAPSED_W  = 33;
  localparam int MUL_A_W    = 20;
  localparam int MUL_B_W    = 18;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int ALU_W      = 36;
  localparam int DIV_STEPS  = 35;
  localparam int SQRT_STEPS = 17;
  localparam int SQRT_TOP   = 32;
  localparam int CNT_W      = 6;

  localparam logic [MUL_A_W-1:0] US_PER_S = 20'd1000000;

  localparam logic [19:0] TARGET_RST  = 20'd0;
  localparam logic [15:0] ACCEL_RST   = 16'd500;
  localparam logic [16:0] CRUISE_RST  = 17'd75000;
  localparam logic [15:0] TOL_RST     = 16'd1000;
  localparam logic [15:0] STOPPED_RST = 16'd5000;
  localparam logic [18:0] LIMIT_RST   = 19'd150000;
  localparam logic [31:0] TIMEOUT_RST = 32'd5000000;
  localparam logic [25:0] K_RST       = 26'd11734176;

  typedef enum logic [1:0] {
    PH_MOVING  = 2'd0,
    PH_REACHED = 2'd1,
    PH_LIMIT   = 2'd2,
    PH_TIMEOUT = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    REG_TARGET  = 3'd0,
    REG_ACCEL   = 3'd1,
    REG_CRUISE  = 3'd2,
    REG_TOL     = 3'd3,
    REG_STOPPED = 3'd4,
    REG_LIMIT   = 3'd5,
    REG_TIMEOUT = 3'd6,
    REG_K       = 3'd7
  } reg_idx_t;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_CHECK    = 11'b000_0000_0010,
    S_MUL_AE   = 11'b000_0000_0100,
    S_MUL_LO   = 11'b000_0000_1000,
    S_MUL_HI   = 11'b000_0001_0000,
    S_MUL_CC   = 11'b000_0010_0000,
    S_DIV_INIT = 11'b000_0100_0000,
    S_DIV      = 11'b000_1000_0000,
    S_CMP      = 11'b001_0000_0000,
    S_SQRT     = 11'b010_0000_0000,
    S_DONE     = 11'b100_0000_0000
  } state_t;

  typedef struct packed {
    logic [19:0] target_position;
    logic [15:0] acceleration;
    logic [16:0] cruise_speed;
    logic [15:0] position_tolerance;
    logic [15:0] stopped_velocity;
    logic [18:0] travel_limit;
    logic [31:0] timeout_us;
    logic [25:0] um_per_rad_q10;
  } cfg_t;

  typedef struct packed {
    logic        start_move;
    logic [19:0] position_um;
    logic [23:0] velocity_um_s;
    logic [15:0] elapsed_step_us;
  } sample_t;

  typedef struct packed {
    logic        valid;
    logic [17:0] cmd;
    phase_t      status;
  } seq_res_t;

endpackage

>>> hdl/sdvl_in_if.sv
`timescale 1ns / 1ps

interface sdvl_in_if;
  logic        valid;
  logic        ready;
  logic        start_move;
  logic [19:0] position_um;
  logic [23:0] velocity_um_s;
  logic [15:0] elapsed_step_us;

  modport source (output valid, start_move, position_um, velocity_um_s, elapsed_step_us,
                  input ready);
  modport sink (input valid, start_move, position_um, velocity_um_s, elapsed_step_us,
                output ready);
endinterface

>>> hdl/sdvl_out_if.sv
`timescale 1ns / 1ps

interface sdvl_out_if;
  logic        valid;
  logic        ready;
  logic [17:0] velocity_command;
  logic [1:0]  move_status;
  logic        motor_enabled;

  modport source (output valid, velocity_command, move_status, motor_enabled, input ready);
  modport sink (input valid, velocity_command, move_status, motor_enabled, output ready);
endinterface

>>> hdl/stop_distance_velocity_limiter_top.sv
`timescale 1ns / 1ps
// A held terminal status or an abort/arrival goes through the check and done states to
// the output register; a velocity command passes at most the check, 4 multiplies, the
// divide steps, a compare, 17 square root steps and the output register. A request is
// taken only while the sequencer is idle; the shared subtractor runs the restoring
// divide and the square root one bit per cycle.
// Reset: registers take their default values, move timer cleared, status moving.

module stop_distance_velocity_limiter_top import sdvl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  sdvl_in_if.sink           sample,
  sdvl_out_if.source        command
);

  cfg_t     cfg;
  sample_t  smp_in;
  seq_res_t res;
  logic     idle;
  logic     take;
  logic     out_valid;
  logic [17:0] out_cmd;
  phase_t   out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_position    <= TARGET_RST;
      cfg.acceleration       <= ACCEL_RST;
      cfg.cruise_speed       <= CRUISE_RST;
      cfg.position_tolerance <= TOL_RST;
      cfg.stopped_velocity   <= STOPPED_RST;
      cfg.travel_limit       <= LIMIT_RST;
      cfg.timeout_us         <= TIMEOUT_RST;
      cfg.um_per_rad_q10     <= K_RST;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_TARGET:  cfg.target_position    <= cfg_data[19:0];
        REG_ACCEL:   cfg.acceleration       <= cfg_data[15:0];
        REG_CRUISE:  cfg.cruise_speed       <= cfg_data[16:0];
        REG_TOL:     cfg.position_tolerance <= cfg_data[15:0];
        REG_STOPPED: cfg.stopped_velocity   <= cfg_data[15:0];
        REG_LIMIT:   cfg.travel_limit       <= cfg_data[18:0];
        REG_TIMEOUT: cfg.timeout_us         <= cfg_data[31:0];
        REG_K:       cfg.um_per_rad_q10     <= cfg_data[25:0];
        default: begin
        end
      endcase
    end
  end

  assign smp_in.start_move      = sample.start_move;
  assign smp_in.position_um     = sample.position_um;
  assign smp_in.velocity_um_s   = sample.velocity_um_s;
  assign smp_in.elapsed_step_us = sample.elapsed_step_us;
  assign sample.ready           = idle;

  sdvl_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .accept (sample.valid && idle),
    .sample (smp_in),
    .take   (take),
    .idle   (idle),
    .res    (res)
  );

  // The output register frees the sequencer as soon as the last result has been taken.
  assign take = res.valid && (!out_valid || command.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (command.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_cmd    <= res.cmd;
      out_status <= res.status;
    end
  end

  assign command.valid            = out_valid;
  assign command.velocity_command = out_cmd;
  assign command.move_status      = out_status;
  assign command.motor_enabled    = !((out_status == PH_LIMIT) || (out_status == PH_TIMEOUT));

endmodule

>>> hdl/sdvl_alu.sv
`timescale 1ns / 1ps

module sdvl_alu import sdvl_pkg::*; (
  input  logic [MUL_A_W-1:0] mul_a,
  input  logic [MUL_B_W-1:0] mul_b,
  input  logic [ALU_W-1:0]   sub_a,
  input  logic [ALU_W-1:0]   sub_b,
  output logic [PROD_W-1:0]  prod,
  output logic [ALU_W-1:0]   diff,
  output logic               ge
);

  logic [ALU_W:0] wide_diff;

  assign prod      = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign wide_diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign diff      = wide_diff[ALU_W-1:0];
  // No borrow out of the top means sub_a is at least sub_b.
  assign ge        = ~wide_diff[ALU_W];

endmodule

>>> hdl/sdvl_seq.sv
`timescale 1ns / 1ps

module sdvl_seq import sdvl_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     accept,
  input  sample_t  sample,
  input  logic     take,
  output logic     idle,
  output seq_res_t res
);

  state_t                 st;
  sample_t                smp;
  logic [ELAPSED_W-1:0]   elapsed;
  phase_t                 phase;
  logic                   err_neg;
  logic [19:0]            aerr;
  logic [35:0]            ae;
  logic [55:0]            nacc;
  logic [33:0]            csq;
  logic [31:0]            rem;
  logic [DIV_STEPS-1:0]   nlo;
  logic [DIV_STEPS-1:0]   quo;
  logic [33:0]            sq_n;
  logic [33:0]            sq_r;
  logic [SQRT_TOP:0]      sq_bit;
  logic [CNT_W-1:0]       cnt;
  logic [17:0]            res_cmd;
  phase_t                 res_status;

  logic [MUL_A_W-1:0]     mul_a;
  logic [MUL_B_W-1:0]     mul_b;
  logic [ALU_W-1:0]       sub_a;
  logic [ALU_W-1:0]       sub_b;
  logic [PROD_W-1:0]      prod;
  logic [ALU_W-1:0]       diff;
  logic                   ge;

  logic [ELAPSED_W:0]     elapsed_sum;
  logic [ELAPSED_W-1:0]   elapsed_eff;
  logic [20:0]            err_c;
  logic [20:0]            err_abs;
  logic [19:0]            abs_pos;
  logic [23:0]            abs_vel;
  logic                   held;
  logic                   over_limit;
  logic                   timed_out;
  logic                   reached;
  logic [26:0]            div_trial;
  logic [33:0]            sq_r_next;

  function automatic logic [17:0] signed_cmd(input logic neg, input logic [16:0] mag);
    logic [17:0] m;
    m = {1'b0, mag};
    return neg ? (~m + 18'd1) : m;
  endfunction

  sdvl_alu u_alu (
    .mul_a (mul_a),
    .mul_b (mul_b),
    .sub_a (sub_a),
    .sub_b (sub_b),
    .prod  (prod),
    .diff  (diff),
    .ge    (ge)
  );

  // Sample checks, all evaluated in the check state.
  always_comb begin
    elapsed_sum = {1'b0, elapsed} + (ELAPSED_W + 1)'(smp.elapsed_step_us);
    elapsed_eff = smp.start_move ? '0 :
                  (elapsed_sum[ELAPSED_W] ? '1 : elapsed_sum[ELAPSED_W-1:0]);
    err_c       = {cfg.target_position[19], cfg.target_position}
                - {smp.position_um[19], smp.position_um};
    err_abs     = err_c[20] ? (~err_c + 21'd1) : err_c;
    abs_pos     = smp.position_um[19] ? (~smp.position_um + 20'd1) : smp.position_um;
    abs_vel     = smp.velocity_um_s[23] ? (~smp.velocity_um_s + 24'd1) : smp.velocity_um_s;
    held        = !smp.start_move && (phase != PH_MOVING);
    over_limit  = abs_pos > {1'b0, cfg.travel_limit};
    timed_out   = elapsed_eff > {1'b0, cfg.timeout_us};
    reached     = (err_abs[19:0] <= {4'b0, cfg.position_tolerance})
               && (abs_vel <= {8'b0, cfg.stopped_velocity});
  end

  assign div_trial = {rem[25:0], nlo[DIV_STEPS-1]};
  assign sq_r_next = ge ? ((sq_r >> 1) | {1'b0, sq_bit}) : (sq_r >> 1);

  // Operand selection for the shared multiplier and subtractor.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    sub_a = '0;
    sub_b = '0;
    unique case (st)
      S_MUL_AE: begin
        mul_a = aerr;
        mul_b = {2'b0, cfg.acceleration};
      end
      S_MUL_LO: begin
        mul_a = US_PER_S;
        mul_b = ae[17:0];
      end
      S_MUL_HI: begin
        mul_a = US_PER_S;
        mul_b = ae[35:18];
      end
      S_MUL_CC: begin
        mul_a = {3'b0, cfg.cruise_speed};
        mul_b = {1'b0, cfg.cruise_speed};
      end
      S_DIV_INIT: begin
        sub_a = {4'b0, rem};
        sub_b = {10'b0, cfg.um_per_rad_q10};
      end
      S_DIV: begin
        sub_a = {9'b0, div_trial};
        sub_b = {10'b0, cfg.um_per_rad_q10};
      end
      S_CMP: begin
        sub_a = {1'b0, quo};
        sub_b = {2'b0, csq};
      end
      S_SQRT: begin
        sub_a = {2'b0, sq_n};
        sub_b = {2'b0, sq_r | {1'b0, sq_bit}};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= S_IDLE;
      elapsed <= '0;
      phase   <= PH_MOVING;
    end else begin
      unique case (st)
        S_IDLE: begin
          if (accept) begin
            smp <= sample;
            st  <= S_CHECK;
          end
        end
        S_CHECK: begin
          res_cmd <= '0;
          if (held) begin
            res_status <= phase;
            st         <= S_DONE;
          end else begin
            elapsed <= elapsed_eff;
            err_neg <= err_c[20];
            aerr    <= err_abs[19:0];
            priority if (over_limit) begin
              phase      <= PH_LIMIT;
              res_status <= PH_LIMIT;
              st         <= S_DONE;
            end else if (timed_out) begin
              phase      <= PH_TIMEOUT;
              res_status <= PH_TIMEOUT;
              st         <= S_DONE;
            end else if (reached) begin
              phase      <= PH_REACHED;
              res_status <= PH_REACHED;
              st         <= S_DONE;
            end else begin
              phase      <= PH_MOVING;
              res_status <= PH_MOVING;
              if (cfg.um_per_rad_q10 == '0) begin
                res_cmd <= signed_cmd(err_c[20], cfg.cruise_speed);
                st      <= S_DONE;
              end else begin
                st <= S_MUL_AE;
              end
            end
          end
        end
        S_MUL_AE: begin
          ae <= prod[35:0];
          st <= S_MUL_LO;
        end
        S_MUL_LO: begin
          nacc <= {18'b0, prod};
          st   <= S_MUL_HI;
        end
        S_MUL_HI: begin
          nacc <= nacc + {prod, 18'b0};
          st   <= S_MUL_CC;
        end
        S_MUL_CC: begin
          // The dividend is nacc scaled by 2048: its top 32 bits seed the remainder.
          csq <= prod[33:0];
          rem <= nacc[55:24];
          nlo <= {nacc[23:0], 11'b0};
          st  <= S_DIV_INIT;
        end
        S_DIV_INIT: begin
          if (ge) begin
            // The quotient exceeds every possible cruise squared.
            res_cmd <= signed_cmd(err_neg, cfg.cruise_speed);
            st      <= S_DONE;
          end else begin
            quo <= '0;
            cnt <= CNT_W'(DIV_STEPS - 1);
            st  <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= ge ? diff[31:0] : {5'b0, div_trial};
          quo <= {quo[DIV_STEPS-2:0], ge};
          nlo <= {nlo[DIV_STEPS-2:0], 1'b0};
          cnt <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            st <= S_CMP;
          end
        end
        S_CMP: begin
          if (ge) begin
            res_cmd <= signed_cmd(err_neg, cfg.cruise_speed);
            st      <= S_DONE;
          end else begin
            sq_n   <= quo[33:0];
            sq_r   <= '0;
            sq_bit <= (SQRT_TOP + 1)'(1) << SQRT_TOP;
            cnt    <= CNT_W'(SQRT_STEPS - 1);
            st     <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (ge) begin
            sq_n <= diff[33:0];
          end
          sq_r   <= sq_r_next;
          sq_bit <= sq_bit >> 2;
          cnt    <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            res_cmd <= signed_cmd(err_neg, sq_r_next[16:0]);
            st      <= S_DONE;
          end
        end
        S_DONE: begin
          if (take) begin
            st <= S_IDLE;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

  assign idle       = (st == S_IDLE);
  assign res.valid  = (st == S_DONE);
  assign res.cmd    = res_cmd;
  assign res.status = res_status;

endmodule

>>> hdl/sdvl_checker.sv
`timescale 1ns / 1ps
`include "stop_distance_velocity_limiter_top_defines.svh"

module sdvl_checker import sdvl_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [17:0] out_cmd,
  input logic [1:0]  out_status,
  input logic        out_enabled
);

  `SDVL_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_cmd) && $stable(out_status), "stalled result changed")
  `SDVL_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready, "request accepted while busy")
  `SDVL_ASSERT_NOW(a_abort_off, clk, rst, out_valid && (out_status == PH_LIMIT || out_status == PH_TIMEOUT), !out_enabled && (out_cmd == '0), "abort without motor off")
  `SDVL_ASSERT_NOW(a_reached_still, clk, rst, out_valid && (out_status == PH_REACHED), out_enabled && (out_cmd == '0), "arrival with nonzero command")
  `SDVL_ASSERT_NOW(a_moving_on, clk, rst, out_valid && (out_status == PH_MOVING), out_enabled, "motor off while moving")

endmodule

bind stop_distance_velocity_limiter_top sdvl_checker u_sdvl_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (sample.valid),
  .in_ready    (sample.ready),
  .out_valid   (command.valid),
  .out_ready   (command.ready),
  .out_cmd     (command.velocity_command),
  .out_status  (command.move_status),
  .out_enabled (command.motor_enabled)
);
